[design/fsvq_pkg.sv]
// Shared types and constants for the flow sensor validity qualifier.
package fsvq_pkg;

  // Configuration register map, one 32-bit register every four bytes.
  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [1:0] {
    REG_QUALITY_THRESHOLD = 2'd0,
    REG_QUALITY_HOLD_MS   = 2'd1,
    REG_HEIGHT_CEILING_CM = 2'd2,
    REG_HEIGHT_HOLD_MS    = 2'd3
  } reg_idx_e;

  // Field widths.
  localparam int unsigned TickWidth    = 8;
  localparam int unsigned QualityWidth = 8;
  localparam int unsigned HoldWidth    = 15;
  localparam int unsigned HeightWidth  = 16;
  localparam int unsigned TimerWidth   = 16;

  // Register values after reset.
  localparam logic [QualityWidth-1:0] QualityThresholdRst = 8'd50;
  localparam logic [HoldWidth-1:0]    QualityHoldRst      = 15'd500;
  localparam logic [HeightWidth-1:0]  HeightCeilingRst    = 16'd600;
  localparam logic [HoldWidth-1:0]    HeightHoldRst       = 15'd1000;

  // Upper limit of the signed height timer.
  localparam logic signed [TimerWidth-1:0] HeightTimerMax = 16'sd32767;

endpackage

[design/flow_sensor_validity_qualifier.sv]
// Top level of the flow sensor validity qualifier: registers, tick logic and APB port.
//
//   Channel   Handshake                 Content
//   --------  ------------------------  ------------------------------------------
//   in        in_valid_i / in_ready_o   one control tick with sensor readings
//   out       out_valid_o / out_ready_i enables and last valid height
//   config    psel/penable/pwrite       four 32-bit registers at byte offsets 0..12
//
// A word is taken into an input register, evaluated against the qualifier state
// combinationally, and its result lands in the output register; one word per cycle is
// sustained when not stalled. The input register keeps accepting while the output
// register drains; a stall on the output side holds both stages. Reset clears the
// timers, flags and stage valids and loads the register defaults.
module flow_sensor_validity_qualifier
  import fsvq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [TickWidth-1:0]    tick_ms_i,
  input  logic                    main_flow_present_i,
  input  logic                    fused_flow_present_i,
  input  logic [QualityWidth-1:0] main_quality_i,
  input  logic [HeightWidth-1:0]  main_height_cm_i,
  input  logic [QualityWidth-1:0] fused_quality_i,
  input  logic [HeightWidth-1:0]  range_height_cm_i,
  input  logic                    position_hold_mode_i,
  input  logic                    uwb_online_i,
  input  logic                    vision_offline_i,

  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    flow_enable_o,
  output logic                    flow_range_enable_o,
  output logic                    uwb_enable_o,
  output logic                    vision_enable_o,
  output logic [HeightWidth-1:0]  valid_height_cm_o,

  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrWidth-1:0]    paddr,
  input  logic [DataWidth-1:0]    pwdata,
  output logic [DataWidth-1:0]    prdata,
  output logic                    pready
);

  // Configuration registers.
  logic [QualityWidth-1:0] quality_threshold_q;
  logic [HoldWidth-1:0]    quality_hold_ms_q;
  logic [HeightWidth-1:0]  height_ceiling_cm_q;
  logic [HoldWidth-1:0]    height_hold_ms_q;
  reg_idx_e                reg_idx;
  logic                    cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quality_threshold_q <= QualityThresholdRst;
      quality_hold_ms_q   <= QualityHoldRst;
      height_ceiling_cm_q <= HeightCeilingRst;
      height_hold_ms_q    <= HeightHoldRst;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_QUALITY_THRESHOLD: quality_threshold_q <= pwdata[QualityWidth-1:0];
        REG_QUALITY_HOLD_MS:   quality_hold_ms_q   <= pwdata[HoldWidth-1:0];
        REG_HEIGHT_CEILING_CM: height_ceiling_cm_q <= pwdata[HeightWidth-1:0];
        REG_HEIGHT_HOLD_MS:    height_hold_ms_q    <= pwdata[HoldWidth-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_idx)
      REG_QUALITY_THRESHOLD: prdata = {{(DataWidth-QualityWidth){1'b0}}, quality_threshold_q};
      REG_QUALITY_HOLD_MS:   prdata = {{(DataWidth-HoldWidth){1'b0}}, quality_hold_ms_q};
      REG_HEIGHT_CEILING_CM: prdata = {{(DataWidth-HeightWidth){1'b0}}, height_ceiling_cm_q};
      REG_HEIGHT_HOLD_MS:    prdata = {{(DataWidth-HoldWidth){1'b0}}, height_hold_ms_q};
      default:               prdata = '0;
    endcase
  end

  // Pipeline control: the input stage moves on when the output register is free or being drained.
  logic in_valid_q;
  logic out_valid_q;
  logic advance;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input register.
  logic [TickWidth-1:0]    tick_q;
  logic                    main_present_q;
  logic                    fused_present_q;
  logic [QualityWidth-1:0] main_quality_q;
  logic [HeightWidth-1:0]  main_height_q;
  logic [QualityWidth-1:0] fused_quality_q;
  logic [HeightWidth-1:0]  range_height_q;
  logic                    hold_mode_q;
  logic                    uwb_online_q;
  logic                    vision_offline_q;

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      tick_q           <= tick_ms_i;
      main_present_q   <= main_flow_present_i;
      fused_present_q  <= fused_flow_present_i;
      main_quality_q   <= main_quality_i;
      main_height_q    <= main_height_cm_i;
      fused_quality_q  <= fused_quality_i;
      range_height_q   <= range_height_cm_i;
      hold_mode_q      <= position_hold_mode_i;
      uwb_online_q     <= uwb_online_i;
      vision_offline_q <= vision_offline_i;
    end
  end

  // Qualifier state.
  logic [TimerWidth-1:0]        quality_timer_q, quality_timer_d;
  logic                         quality_good_q, quality_good_d;
  logic signed [TimerWidth-1:0] height_timer_q, height_timer_d;
  logic                         height_good_q, height_good_d;
  logic                         range_pending_q, range_pending_d;
  logic [HeightWidth-1:0]       last_height_q, last_height_d;
  logic                         flow_en;
  logic                         range_en;

  // Selected source and the counting arithmetic.
  logic [QualityWidth-1:0] sel_quality;
  logic [HeightWidth-1:0]  sel_height;
  logic [TimerWidth:0]     height_sum;
  logic                    height_below_hold;
  logic                    height_positive;

  assign sel_quality       = main_present_q ? main_quality_q : fused_quality_q;
  assign sel_height        = main_present_q ? main_height_q : range_height_q;
  assign height_sum        = {height_timer_q[TimerWidth-1], height_timer_q}
                           + {{(TimerWidth+1-TickWidth){1'b0}}, tick_q};
  assign height_below_hold = height_timer_q < $signed({1'b0, height_hold_ms_q});
  assign height_positive   = !height_timer_q[TimerWidth-1] && (height_timer_q != '0);

  // Per-tick update of timers, flags and enables.
  always_comb begin
    quality_timer_d = quality_timer_q;
    quality_good_d  = quality_good_q;
    height_timer_d  = height_timer_q;
    height_good_d   = height_good_q;
    range_pending_d = range_pending_q;
    last_height_d   = last_height_q;
    flow_en         = 1'b0;
    range_en        = 1'b0;

    if (main_present_q || fused_present_q) begin
      // Quality must stay above threshold for the hold time.
      if (sel_quality > quality_threshold_q) begin
        if (quality_timer_q < {1'b0, quality_hold_ms_q}) begin
          quality_timer_d = quality_timer_q + {{(TimerWidth-TickWidth){1'b0}}, tick_q};
        end else begin
          quality_good_d = 1'b1;
        end
      end else begin
        quality_timer_d = '0;
        quality_good_d  = 1'b0;
      end

      // Height timer counts up below the ceiling and down at or above it.
      if (sel_height < height_ceiling_cm_q) begin
        last_height_d = sel_height;
        if (height_below_hold) begin
          if (!height_sum[TimerWidth] && height_sum[TimerWidth-1]) begin
            height_timer_d = HeightTimerMax;
          end else begin
            height_timer_d = $signed(height_sum[TimerWidth-1:0]);
          end
        end else begin
          height_good_d   = 1'b1;
          range_pending_d = 1'b1;
        end
      end else begin
        if (height_positive) begin
          height_timer_d = height_timer_q - $signed({{(TimerWidth-TickWidth){1'b0}}, tick_q});
        end else begin
          height_good_d   = 1'b0;
          range_pending_d = 1'b0;
        end
      end

      // Position hold gates both flow enables.
      if (hold_mode_q) begin
        flow_en = height_good_d && quality_good_d;
      end else begin
        range_pending_d = 1'b0;
      end
      range_en = range_pending_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quality_timer_q <= '0;
      quality_good_q  <= 1'b0;
      height_timer_q  <= '0;
      height_good_q   <= 1'b0;
      range_pending_q <= 1'b0;
      last_height_q   <= '0;
    end else if (advance) begin
      quality_timer_q <= quality_timer_d;
      quality_good_q  <= quality_good_d;
      height_timer_q  <= height_timer_d;
      height_good_q   <= height_good_d;
      range_pending_q <= range_pending_d;
      last_height_q   <= last_height_d;
    end
  end

  // Output register.
  logic                   flow_enable_q;
  logic                   flow_range_enable_q;
  logic                   uwb_enable_q;
  logic                   vision_enable_q;
  logic [HeightWidth-1:0] valid_height_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      flow_enable_q       <= flow_en;
      flow_range_enable_q <= range_en;
      uwb_enable_q        <= uwb_online_q && hold_mode_q;
      vision_enable_q     <= !vision_offline_q && hold_mode_q;
      valid_height_q      <= last_height_d;
    end
  end

  assign flow_enable_o       = flow_enable_q;
  assign flow_range_enable_o = flow_range_enable_q;
  assign uwb_enable_o        = uwb_enable_q;
  assign vision_enable_o     = vision_enable_q;
  assign valid_height_cm_o   = valid_height_q;

endmodule
